/* design/rrss_pkg.sv */
// Shared types and constants of the refresh-rate switch sequencer.
`timescale 1ns / 1ps

package rrss_pkg;

    localparam int RATE_BITS = 10;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [RATE_BITS-1:0] RESET_RATE = RATE_BITS'(60);
    localparam logic [1:0] TE_SKIP_ONE = 2'd1;
    localparam logic [1:0] TE_SKIP_TWO = 2'd2;

    typedef enum logic [2:0] {
        OP_RATE_REQ   = 3'd0,
        OP_VACT_START = 3'd1,
        OP_VACT_END   = 3'd2,
        OP_COMMIT     = 3'd3,
        OP_TE_PULSE   = 3'd4,
        OP_RELEASE    = 3'd5,
        OP_SETUP      = 3'd6
    } t_opcode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PFM_SUPPORTED = 2'd0,
        CFG_TE_SUPPORTED  = 2'd1,
        CFG_BASE_RATE     = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        PFM_AT_BASE    = 2'd0,
        PFM_MODE_FIRST = 2'd1,
        PFM_RATE_FIRST = 2'd2
    } t_pfm;

    typedef struct packed {
        logic                 pfm_supported;
        logic                 te_mode_supported;
        logic [RATE_BITS-1:0] base_rate;
    } t_cfg;

    typedef struct packed {
        logic [RATE_BITS-1:0] requested_rate;
        logic [RATE_BITS-1:0] applied_rate;
        logic [RATE_BITS-1:0] before_request_rate;
        logic                 in_vactive;
        t_pfm                 pfm_state;
        logic [1:0]           te_skip_count;
        logic                 commit_pending;
        logic                 events_enabled;
    } t_seq_state;

    typedef struct packed {
        logic                 start_frame;
        logic                 commit_held;
        logic                 set_pfm_mode;
        logic                 apply_rate;
        logic                 switch_te_mode;
        logic [RATE_BITS-1:0] current_rate;
    } t_result;

endpackage

/* design/rrss_event_logic.sv */
// Next-state and result logic for one sequencer event.
`timescale 1ns / 1ps

module rrss_event_logic
    import rrss_pkg::*;
(
    input  t_cfg                 i_cfg,
    input  t_seq_state           i_state,
    input  logic [2:0]           i_opcode,
    input  logic [RATE_BITS-1:0] i_rate,
    output t_seq_state           o_state,
    output t_result              o_result
);

    logic       pfm_end;
    logic [1:0] skip_next;
    logic       rate_changed;
    logic       rate_falls;

    assign rate_changed = (i_state.applied_rate != i_state.requested_rate);
    assign rate_falls   = (i_state.before_request_rate > i_state.requested_rate) ||
                          (i_state.applied_rate > i_state.requested_rate);

    always_comb begin
        o_state   = i_state;
        o_result  = '0;
        pfm_end   = 1'b0;
        skip_next = i_state.te_skip_count;

        case (t_opcode'(i_opcode))
            OP_RATE_REQ: begin
                o_state.before_request_rate = i_state.requested_rate;
                o_state.requested_rate      = i_rate;
            end
            OP_VACT_START: begin
                if (i_state.events_enabled) begin
                    o_state.in_vactive = 1'b1;
                end
            end
            OP_VACT_END: begin
                o_state.in_vactive = 1'b0;
                if (i_cfg.pfm_supported) begin
                    if (!rate_changed && i_state.pfm_state == PFM_RATE_FIRST) begin
                        o_state.pfm_state = PFM_AT_BASE;
                        pfm_end           = 1'b1;
                    end else if (rate_changed && i_state.applied_rate == i_cfg.base_rate &&
                                 i_state.pfm_state == PFM_AT_BASE) begin
                        o_state.pfm_state = PFM_MODE_FIRST;
                        pfm_end           = 1'b1;
                    end else if (rate_changed &&
                                 i_state.requested_rate == i_cfg.base_rate) begin
                        o_state.pfm_state = PFM_RATE_FIRST;
                    end
                end
                if (pfm_end) begin
                    o_result.set_pfm_mode = 1'b1;
                end else if (rate_changed) begin
                    if (i_state.applied_rate > i_state.requested_rate) begin
                        o_state.te_skip_count = i_cfg.te_mode_supported ?
                                                TE_SKIP_TWO : TE_SKIP_ONE;
                    end
                    o_result.apply_rate     = 1'b1;
                    o_result.switch_te_mode = i_cfg.te_mode_supported;
                    o_state.applied_rate    = i_state.requested_rate;
                end
            end
            OP_COMMIT: begin
                if (i_state.commit_pending || i_state.te_skip_count != 2'd0 ||
                    (rate_falls && i_state.in_vactive)) begin
                    o_state.commit_pending = 1'b1;
                    o_result.commit_held   = 1'b1;
                end else begin
                    o_result.start_frame = 1'b1;
                end
            end
            OP_TE_PULSE: begin
                if (i_state.events_enabled) begin
                    if (i_state.te_skip_count != 2'd0) begin
                        skip_next = i_state.te_skip_count - 2'd1;
                    end
                    o_state.te_skip_count = skip_next;
                    if (skip_next == 2'd0 && i_state.commit_pending) begin
                        o_result.start_frame   = 1'b1;
                        o_state.commit_pending = 1'b0;
                    end
                end
            end
            OP_RELEASE: begin
                o_state.requested_rate = i_state.applied_rate;
                o_state.events_enabled = 1'b0;
            end
            OP_SETUP: begin
                o_state.before_request_rate = i_state.applied_rate;
                o_state.in_vactive          = 1'b0;
                o_state.pfm_state           = PFM_AT_BASE;
                o_state.te_skip_count       = 2'd0;
                o_state.commit_pending      = 1'b0;
                o_state.events_enabled      = 1'b1;
            end
            default: begin
            end
        endcase

        o_result.current_rate = o_state.requested_rate;
    end

endmodule

/* design/refresh_rate_switch_sequencer.sv */
// Top level of the refresh-rate switch sequencer: state, result register, config port.
// A result is registered and valid in the cycle after its event beat is accepted.
// One event per cycle unless the output stalls; the state update and the result
// come from one compare-and-update pass between the state and result registers.
// Reset (synchronous, active low): rates return to 60 Hz, flags and counts clear,
// events are enabled, configuration returns to its defaults and the output empties.
`timescale 1ns / 1ps

module refresh_rate_switch_sequencer
    import rrss_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [2:0]              i_opcode,
    input  logic [RATE_BITS-1:0]    i_rate,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_start_frame,
    output logic                    o_commit_held,
    output logic                    o_set_pfm_mode,
    output logic                    o_apply_rate,
    output logic                    o_switch_te_mode,
    output logic [RATE_BITS-1:0]    o_current_rate,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [RATE_BITS-1:0]    i_cfg_data
);

    t_cfg       r_cfg;
    t_seq_state r_state;
    t_seq_state n_state;
    t_result    r_result;
    t_result    n_result;
    logic       r_out_valid;
    logic       in_beat;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_beat     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    rrss_event_logic u_event_logic (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_opcode (i_opcode),
        .i_rate   (i_rate),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pfm_supported           <= 1'b0;
            r_cfg.te_mode_supported       <= 1'b0;
            r_cfg.base_rate               <= RESET_RATE;
            r_state.requested_rate        <= RESET_RATE;
            r_state.applied_rate          <= RESET_RATE;
            r_state.before_request_rate   <= RESET_RATE;
            r_state.in_vactive            <= 1'b0;
            r_state.pfm_state             <= PFM_AT_BASE;
            r_state.te_skip_count         <= 2'd0;
            r_state.commit_pending        <= 1'b0;
            r_state.events_enabled        <= 1'b1;
            r_out_valid                   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_PFM_SUPPORTED: r_cfg.pfm_supported     <= i_cfg_data[0];
                    CFG_TE_SUPPORTED:  r_cfg.te_mode_supported <= i_cfg_data[0];
                    CFG_BASE_RATE:     r_cfg.base_rate         <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_beat) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until the downstream beat completes.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_start_frame    = r_result.start_frame;
    assign o_commit_held    = r_result.commit_held;
    assign o_set_pfm_mode   = r_result.set_pfm_mode;
    assign o_apply_rate     = r_result.apply_rate;
    assign o_switch_te_mode = r_result.switch_te_mode;
    assign o_current_rate   = r_result.current_rate;

endmodule

/* test/refresh_rate_switch_sequencer_tb.sv */
// Self-checking testbench of the refresh-rate switch sequencer: directed and random event beats.
`timescale 1ns / 1ps

module refresh_rate_switch_sequencer_tb;
    import rrss_pkg::*;

    localparam logic [2:0]              OP_UNUSED   = 3'd7;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED  = 2'd3;
    localparam int                      STALL_LIMIT = 2000;
    localparam int                      MAX_REPORTS = 10;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [2:0]              i_opcode;
    logic [RATE_BITS-1:0]    i_rate;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_start_frame;
    logic                    o_commit_held;
    logic                    o_set_pfm_mode;
    logic                    o_apply_rate;
    logic                    o_switch_te_mode;
    logic [RATE_BITS-1:0]    o_current_rate;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [RATE_BITS-1:0]    i_cfg_data;

    // sequencer state as predicted
    logic                 cfg_pfm        = 1'b0;
    logic                 cfg_te         = 1'b0;
    logic [RATE_BITS-1:0] cfg_base       = RESET_RATE;
    logic [RATE_BITS-1:0] req_rate       = RESET_RATE;
    logic [RATE_BITS-1:0] applied_rate   = RESET_RATE;
    logic [RATE_BITS-1:0] prior_rate     = RESET_RATE;
    logic                 in_vactive     = 1'b0;
    t_pfm                 pfm_phase      = PFM_AT_BASE;
    logic [1:0]           te_skips       = 2'd0;
    logic                 commit_waiting = 1'b0;
    logic                 events_on      = 1'b1;

    t_result predicted_actions[$];

    bit sender_idles;
    bit sink_stalls;
    int mismatches     = 0;
    int items_sent     = 0;
    int events_taken   = 0;
    int settings_used  = 0;
    int frames_started = 0;
    int commits_held   = 0;
    int pfm_updates    = 0;
    int rates_applied  = 0;
    int quiet_cycles   = 0;

    refresh_rate_switch_sequencer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_rate           (i_rate),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_start_frame    (o_start_frame),
        .o_commit_held    (o_commit_held),
        .o_set_pfm_mode   (o_set_pfm_mode),
        .o_apply_rate     (o_apply_rate),
        .o_switch_te_mode (o_switch_te_mode),
        .o_current_rate   (o_current_rate),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result sequence_event(input logic [2:0] op,
                                               input logic [RATE_BITS-1:0] rate);
        t_result act;
        logic    pfm_done;
        act = '0;
        pfm_done = 1'b0;
        case (op)
            OP_RATE_REQ: begin
                prior_rate = req_rate;
                req_rate = rate;
            end
            OP_VACT_START: begin
                if (events_on) begin
                    in_vactive = 1'b1;
                end
            end
            OP_VACT_END: begin
                in_vactive = 1'b0;
                if (cfg_pfm) begin
                    if (applied_rate == req_rate && pfm_phase == PFM_RATE_FIRST) begin
                        pfm_phase = PFM_AT_BASE;
                        pfm_done = 1'b1;
                    end else if (applied_rate != req_rate && applied_rate == cfg_base &&
                                 pfm_phase == PFM_AT_BASE) begin
                        pfm_phase = PFM_MODE_FIRST;
                        pfm_done = 1'b1;
                    end else if (applied_rate != req_rate && req_rate == cfg_base) begin
                        pfm_phase = PFM_RATE_FIRST;
                    end
                end
                if (pfm_done) begin
                    act.set_pfm_mode = 1'b1;
                end else if (applied_rate != req_rate) begin
                    if (applied_rate > req_rate) begin
                        te_skips = cfg_te ? TE_SKIP_TWO : TE_SKIP_ONE;
                    end
                    act.apply_rate = 1'b1;
                    act.switch_te_mode = cfg_te;
                    applied_rate = req_rate;
                end
            end
            OP_COMMIT: begin
                if (commit_waiting || te_skips != 2'd0) begin
                    commit_waiting = 1'b1;
                    act.commit_held = 1'b1;
                end else if ((prior_rate > req_rate || applied_rate > req_rate) &&
                             in_vactive) begin
                    commit_waiting = 1'b1;
                    act.commit_held = 1'b1;
                end else begin
                    act.start_frame = 1'b1;
                end
            end
            OP_TE_PULSE: begin
                if (events_on) begin
                    if (te_skips != 2'd0) begin
                        te_skips = te_skips - 2'd1;
                    end
                    if (te_skips == 2'd0 && commit_waiting) begin
                        act.start_frame = 1'b1;
                        commit_waiting = 1'b0;
                    end
                end
            end
            OP_RELEASE: begin
                req_rate = applied_rate;
                events_on = 1'b0;
            end
            OP_SETUP: begin
                prior_rate = applied_rate;
                in_vactive = 1'b0;
                pfm_phase = PFM_AT_BASE;
                te_skips = 2'd0;
                commit_waiting = 1'b0;
                events_on = 1'b1;
            end
            default: begin
            end
        endcase
        act.current_rate = req_rate;
        return act;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = {o_start_frame, o_commit_held, o_set_pfm_mode, o_apply_rate,
                       o_switch_te_mode, o_current_rate};
                if (predicted_actions.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result beat at %0t, rate %0d", $time,
                                 o_current_rate);
                    end
                end else begin
                    want = predicted_actions.pop_front();
                    if (got.start_frame !== want.start_frame ||
                        got.commit_held !== want.commit_held ||
                        got.set_pfm_mode !== want.set_pfm_mode ||
                        got.apply_rate !== want.apply_rate ||
                        got.switch_te_mode !== want.switch_te_mode ||
                        got.current_rate !== want.current_rate) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch at %0t: exp start=%0b held=%0b pfm=%0b",
                                     $time, want.start_frame, want.commit_held,
                                     want.set_pfm_mode,
                                     " apply=%0b te=%0b rate=%0d", want.apply_rate,
                                     want.switch_te_mode, want.current_rate);
                            $display("    got start=%0b held=%0b pfm=%0b apply=%0b te=%0b rate=%0d",
                                     got.start_frame, got.commit_held, got.set_pfm_mode,
                                     got.apply_rate, got.switch_te_mode, got.current_rate);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PFM_SUPPORTED: cfg_pfm = i_cfg_data[0];
                    CFG_TE_SUPPORTED:  cfg_te = i_cfg_data[0];
                    CFG_BASE_RATE:     cfg_base = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                want = sequence_event(i_opcode, i_rate);
                predicted_actions.push_back(want);
                events_taken++;
                frames_started += want.start_frame;
                commits_held += want.commit_held;
                pfm_updates += want.set_pfm_mode;
                rates_applied += want.apply_rate;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= sink_stalls ? ($urandom_range(99) >= 21) : 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("refresh_rate_switch_sequencer_tb NOT OK");
        $finish;
    end

    function automatic logic [RATE_BITS-1:0] draw_rate();
        case ($urandom_range(5))
            0: return cfg_base;
            1: return '0;
            2: return '1;
            3: return applied_rate;
            4: return RATE_BITS'($urandom_range(30, 144));
            default: return RATE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_event(input logic [2:0] op, input logic [RATE_BITS-1:0] rate);
        if (sender_idles && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_rate <= rate;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (predicted_actions.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [RATE_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input bit pfm, input bit te,
                                  input logic [RATE_BITS-1:0] base);
        drain_results();
        write_register(CFG_PFM_SUPPORTED, {(RATE_BITS-1)'($urandom_range(511)), pfm});
        write_register(CFG_TE_SUPPORTED, {(RATE_BITS-1)'($urandom_range(511)), te});
        write_register(CFG_BASE_RATE, base);
        settings_used++;
    endtask

    task automatic send_frame();
        if ($urandom_range(99) < 40) begin
            send_event(OP_RATE_REQ, draw_rate());
        end
        send_event(OP_VACT_START, RATE_BITS'($urandom));
        if ($urandom_range(99) < 50) begin
            send_event(OP_COMMIT, RATE_BITS'($urandom));
        end
        send_event(OP_VACT_END, RATE_BITS'($urandom));
        repeat ($urandom_range(1, 3)) begin
            send_event(OP_TE_PULSE, RATE_BITS'($urandom));
            if ($urandom_range(99) < 40) begin
                send_event(OP_COMMIT, RATE_BITS'($urandom));
            end
        end
        if ($urandom_range(99) < 5) begin
            send_event(OP_RELEASE, RATE_BITS'($urandom));
        end
        if ($urandom_range(99) < 6) begin
            send_event(OP_SETUP, RATE_BITS'($urandom));
        end
    endtask

    task automatic test_default_sequencing();
        settings_used++;
        send_event(OP_COMMIT, '0);
        send_event(OP_TE_PULSE, '1);
        send_event(OP_RATE_REQ, 10'd1023);
        send_event(OP_VACT_END, '0);
        send_event(OP_RATE_REQ, 10'd0);
        send_event(OP_VACT_START, '0);
        send_event(OP_COMMIT, '0);
        send_event(OP_VACT_END, '0);
        send_event(OP_COMMIT, '0);
        send_event(OP_TE_PULSE, '0);
        send_event(OP_UNUSED, '1);
        send_event(OP_RELEASE, '0);
        send_event(OP_RATE_REQ, 10'd512);
        send_event(OP_RELEASE, '1);
        send_event(OP_VACT_START, '0);
        send_event(OP_TE_PULSE, '0);
        send_event(OP_COMMIT, '0);
        send_event(OP_RATE_REQ, 10'd341);
        send_event(OP_VACT_END, '0);
        send_event(OP_SETUP, '1);
    endtask

    task automatic test_pfm_handshake();
        apply_settings(1'b1, 1'b1, RESET_RATE);
        send_event(OP_SETUP, '0);
        send_event(OP_RATE_REQ, RESET_RATE);
        repeat (3) send_event(OP_VACT_END, '0);
        send_event(OP_RATE_REQ, 10'd120);
        send_event(OP_VACT_END, '0);
        send_event(OP_VACT_END, '0);
        send_event(OP_RATE_REQ, RESET_RATE);
        send_event(OP_VACT_START, '0);
        send_event(OP_VACT_END, '0);
        send_event(OP_VACT_END, '0);
        send_event(OP_COMMIT, '0);
        send_event(OP_TE_PULSE, '0);
        send_event(OP_TE_PULSE, '0);
    endtask

    task automatic test_random_frames();
        int target;
        for (int s = 0; s < 6; s++) begin
            sender_idles = (s != 2);
            sink_stalls = (s != 2);
            case (s)
                0: apply_settings(1'b0, 1'b0, RESET_RATE);
                1: apply_settings(1'b1, 1'b0, RESET_RATE);
                2: apply_settings(1'b0, 1'b1, 10'd1);
                3: apply_settings(1'b1, 1'b1, 10'd1023);
                4: apply_settings(1'b1, 1'b1, RATE_BITS'($urandom_range(1, 1023)));
                default: apply_settings(1'b1, 1'b0, RATE_BITS'($urandom_range(1, 1023)));
            endcase
            send_event(OP_SETUP, '0);
            target = items_sent + 105;
            while (items_sent < target) begin
                send_frame();
                if ($urandom_range(99) < 3) begin
                    drain_results();
                end
            end
        end
        sender_idles = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic test_unused_register();
        drain_results();
        write_register(CFG_UNUSED, '1);
        repeat (4) send_frame();
    endtask

    task automatic test_noise_events();
        apply_settings(1'b1, 1'b1, RESET_RATE);
        repeat (120) begin
            send_event(3'($urandom_range(7)),
                       ($urandom_range(1)) ? draw_rate() : RATE_BITS'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_opcode = OP_RATE_REQ;
        i_rate = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PFM_SUPPORTED;
        i_cfg_data = '0;
        sender_idles = 1'b1;
        sink_stalls = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_sequencing();
        test_pfm_handshake();
        test_random_frames();
        test_unused_register();
        test_noise_events();

        drain_results();
        repeat (3) @(negedge i_clk);
        $display("ran %0d events over %0d register settings,", events_taken, settings_used,
                 " with random sender gaps and sink stalls");
        $display("saw %0d frame starts, %0d held commits, %0d PFM updates, %0d rate applies",
                 frames_started, commits_held, pfm_updates, rates_applied);
        if (mismatches == 0) begin
            $display("refresh_rate_switch_sequencer_tb OK");
        end else begin
            $display("refresh_rate_switch_sequencer_tb NOT OK");
        end
        $finish;
    end

endmodule
